[rtl/pixel_to_hex_cell_macros.svh]
// Assertion helpers shared by the checker. Each expects aclk in scope, the first two also aresetn.
`ifndef PIXEL_TO_HEX_CELL_MACROS_SVH
`define PIXEL_TO_HEX_CELL_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define PHC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define PHC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define PHC_ASSERT_NEXT_RST(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/phc_pkg.sv]
package phc_pkg;

    // Fixed point
    localparam int PHC_FRAC_BITS = 16;
    localparam int PHC_INV_FRAC  = 16;

    // Pipeline register stages, input to output register
    localparam int PHC_STAGES = 8;

    // Field widths
    localparam int PHC_PIX_W  = 16;
    localparam int PHC_CELL_W = 17;
    localparam int PHC_ADDR_W = 2;

    // Register indexes
    localparam logic [PHC_ADDR_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [PHC_ADDR_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [PHC_ADDR_W-1:0] REG_INV_SIZE = 2'd2;

    // Register reset values
    localparam logic [15:0] ORIGIN_X_RST = 16'd100;
    localparam logic [15:0] ORIGIN_Y_RST = 16'd100;
    localparam logic [15:0] INV_SIZE_RST = 16'd1638;

    // Scale constants as Q0.32 fractions
    localparam logic [63:0] K_SQRT3_3_Q32   = 64'd2479700524;
    localparam logic [63:0] K_THIRD_Q32     = 64'd1431655765;
    localparam logic [63:0] K_TWO_THIRD_Q32 = 64'd2863311531;

    // Round a Q0.32 fraction to nearest at fb fraction bits
    function automatic logic [63:0] phc_kround(input logic [63:0] c, input int fb);
        logic [63:0] half;
        half = 64'd1 << (31 - fb);
        return (c + half) >> (32 - fb);
    endfunction

endpackage

[rtl/pixel_to_hex_cell.sv]
// Channel   Direction  Ports                                   Meaning
// s_        in         s_valid s_ready s_pixel_x s_pixel_y     pixel to locate
// m_        out        m_valid m_ready m_cell_q m_cell_r       axial hex coordinate
// cfg_      in         cfg_valid cfg_ready cfg_addr cfg_wdata  origin and 1/size writes
//
// One transaction per cycle sustained while m_ready is high; s_ to m_ passes
// the eight register stages (offset, scale, combine, size multiply, shift,
// rounding, error, select). Stages with no valid data fill in while m_ stalls,
// so s_ready drops only once every stage holds a transaction.
// Reset clears the stage valid bits and loads origin 100, 100 and inv_size 1638.
module pixel_to_hex_cell
    import phc_pkg::*;
#(
    parameter int FRAC_BITS = PHC_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [PHC_PIX_W-1:0]  s_pixel_x,
    input  logic signed [PHC_PIX_W-1:0]  s_pixel_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PHC_CELL_W-1:0] m_cell_q,
    output logic signed [PHC_CELL_W-1:0] m_cell_r,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [PHC_ADDR_W-1:0]        cfg_addr,
    input  logic [15:0]                  cfg_wdata
);

    localparam int NS = PHC_STAGES;
    localparam int DW = PHC_PIX_W + 1;          // offset pixel
    localparam int PW = FRAC_BITS + 1 + DW;     // constant times offset
    localparam int SW = PW + 1;                 // combined q term
    localparam int MW = SW + 17;                // after size multiply
    localparam int FW = MW - PHC_INV_FRAC;      // fractional axial, Q.FRAC_BITS
    localparam int RW = FW - FRAC_BITS;         // rounded integer
    localparam int EW = FRAC_BITS + 1;          // rounding error magnitude

    localparam logic [FRAC_BITS-1:0] K_A = FRAC_BITS'(phc_kround(K_SQRT3_3_Q32, FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] K_B = FRAC_BITS'(phc_kround(K_THIRD_Q32, FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] K_C = FRAC_BITS'(phc_kround(K_TWO_THIRD_Q32, FRAC_BITS));
    localparam logic signed [FW-1:0] HALF = FW'(1) <<< (FRAC_BITS - 1);

    // Configuration registers
    logic signed [15:0] origin_x_reg, origin_y_reg;
    logic [15:0]        inv_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
            inv_size_reg <= INV_SIZE_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_INV_SIZE: inv_size_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage advance: a stage moves when it is empty or the next one moves
    logic [NS:1] valid_reg;
    logic [NS:1] adv;

    always_comb begin
        adv[NS] = !valid_reg[NS] || m_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[1];
    assign m_valid = valid_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[1]) begin
                valid_reg[1] <= s_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Round half away from zero, Q.FRAC_BITS to integer
    function automatic logic signed [RW-1:0] round_haz(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] t;
        if (!v[FW-1]) begin
            t = v + HALF;
            return RW'(t >>> FRAC_BITS);
        end
        t = -v + HALF;
        return -RW'(t >>> FRAC_BITS);
    endfunction

    // Absolute rounding error
    function automatic logic [EW-1:0] round_err(input logic signed [RW-1:0] r,
                                                input logic signed [FW-1:0] v);
        logic signed [FW-1:0] d;
        d = (FW'(r) <<< FRAC_BITS) - v;
        return d[FW-1] ? EW'(-d) : EW'(d);
    endfunction

    // Stage registers
    logic signed [DW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pa_next, pb_next, pc_next;
    logic signed [SW-1:0] sq_reg, sr_reg, sq_next, sr_next;
    logic signed [MW-1:0] mq_reg, mr_reg, mq_next, mr_next;
    logic signed [FW-1:0] fq_reg, fr_reg, fs_reg, fq_next, fr_next, fs_next;
    logic signed [FW-1:0] fq6_reg, fr6_reg, fs6_reg;
    logic signed [RW-1:0] q6_reg, r6_reg, s6_reg, q6_next, r6_next, s6_next;
    logic signed [RW-1:0] q7_reg, r7_reg, s7_reg;
    logic [EW-1:0]        eq_reg, er_reg, es_reg, eq_next, er_next, es_next;
    logic signed [PHC_CELL_W-1:0] cq_reg, cr_reg, cq_next, cr_next;

    always_comb begin
        // Shift by origin
        dx_next = DW'(s_pixel_x) - DW'(origin_x_reg);
        dy_next = DW'(s_pixel_y) - DW'(origin_y_reg);
        // Scale by the axial constants
        pa_next = $signed({1'b0, K_A}) * dx_reg;
        pb_next = $signed({1'b0, K_B}) * dy_reg;
        pc_next = $signed({1'b0, K_C}) * dy_reg;
        // Combine q terms, pass the r term through
        sq_next = SW'(pa_reg) - SW'(pb_reg);
        sr_next = SW'(pc_reg);
        // Multiply by the reciprocal size
        mq_next = sq_reg * $signed({1'b0, inv_size_reg});
        mr_next = sr_reg * $signed({1'b0, inv_size_reg});
        // Drop the reciprocal fraction (floor), derive s
        fq_next = FW'(mq_reg >>> PHC_INV_FRAC);
        fr_next = FW'(mr_reg >>> PHC_INV_FRAC);
        fs_next = -FW'(mq_reg >>> PHC_INV_FRAC) - FW'(mr_reg >>> PHC_INV_FRAC);
        // Round each coordinate
        q6_next = round_haz(fq_reg);
        r6_next = round_haz(fr_reg);
        s6_next = round_haz(fs_reg);
        // Rounding errors
        eq_next = round_err(q6_reg, fq6_reg);
        er_next = round_err(r6_reg, fr6_reg);
        es_next = round_err(s6_reg, fs6_reg);
        // Rebuild the coordinate with the largest error
        cq_next = PHC_CELL_W'(q7_reg);
        cr_next = PHC_CELL_W'(r7_reg);
        if (eq_reg > er_reg && eq_reg > es_reg) begin
            cq_next = PHC_CELL_W'(-r7_reg - s7_reg);
        end else if (er_reg > es_reg) begin
            cr_next = PHC_CELL_W'(-q7_reg - s7_reg);
        end
    end

    // Payload registers, loaded as their stage advances
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (adv[2]) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (adv[3]) begin
            sq_reg <= sq_next;
            sr_reg <= sr_next;
        end
        if (adv[4]) begin
            mq_reg <= mq_next;
            mr_reg <= mr_next;
        end
        if (adv[5]) begin
            fq_reg <= fq_next;
            fr_reg <= fr_next;
            fs_reg <= fs_next;
        end
        if (adv[6]) begin
            q6_reg  <= q6_next;
            r6_reg  <= r6_next;
            s6_reg  <= s6_next;
            fq6_reg <= fq_reg;
            fr6_reg <= fr_reg;
            fs6_reg <= fs_reg;
        end
        if (adv[7]) begin
            eq_reg <= eq_next;
            er_reg <= er_next;
            es_reg <= es_next;
            q7_reg <= q6_reg;
            r7_reg <= r6_reg;
            s7_reg <= s6_reg;
        end
        if (adv[8]) begin
            cq_reg <= cq_next;
            cr_reg <= cr_next;
        end
    end

    assign m_cell_q = cq_reg;
    assign m_cell_r = cr_reg;

endmodule

[rtl/phc_checker.sv]
`include "pixel_to_hex_cell_macros.svh"

module phc_checker
    import phc_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [PHC_CELL_W-1:0] m_cell_q,
    input logic signed [PHC_CELL_W-1:0] m_cell_r
);

    // Track transactions inside the block
    logic [4:0] pend_reg;
    logic [4:0] pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            pend_next = pend_reg + 5'd1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            pend_next = pend_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `PHC_ASSERT_NEXT_RST(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")
    `PHC_ASSERT_NOW(a_no_invented, m_valid, pend_reg != 5'd0, "result without a pending pixel")
    `PHC_ASSERT_NOW(a_depth, 1'b1, pend_reg <= 5'(PHC_STAGES), "more pending than stages")
    `PHC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_cell_q) && $stable(m_cell_r), "stalled result changed")

endmodule

bind pixel_to_hex_cell phc_checker u_phc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_cell_q (m_cell_q),
    .m_cell_r (m_cell_r)
);

[tb/testbench.sv]
module testbench;
    import phc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index outside the map; the block must ignore the write
    localparam logic [PHC_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 112;

    typedef struct packed {
        logic signed [PHC_PIX_W-1:0] x;
        logic signed [PHC_PIX_W-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic signed [PHC_CELL_W-1:0] q;
        logic signed [PHC_CELL_W-1:0] r;
    } hex_cell_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [PHC_PIX_W-1:0]  s_pixel_x = '0;
    logic signed [PHC_PIX_W-1:0]  s_pixel_y = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [PHC_CELL_W-1:0] m_cell_q;
    logic signed [PHC_CELL_W-1:0] m_cell_r;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [PHC_ADDR_W-1:0]        cfg_addr = '0;
    logic [15:0]                  cfg_wdata = '0;

    // Shadow copy of the block's registers
    logic signed [15:0] org_x = ORIGIN_X_RST;
    logic signed [15:0] org_y = ORIGIN_Y_RST;
    logic [15:0]        inv_scale = INV_SIZE_RST;

    pixel_t    pixel_queue[$];
    hex_cell_t cell_queue[$];
    int        fail_count = 0;
    int        src_gap = 0;
    int        sink_gap = 0;
    int        stall_cycles = 0;
    bit        idle_on = 1'b1;

    pixel_to_hex_cell dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel_x (s_pixel_x),
        .s_pixel_y (s_pixel_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_cell_q  (m_cell_q),
        .m_cell_r  (m_cell_r),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Round a fixed-point value half away from zero to an integer
    function automatic longint round_away(longint v);
        longint half;
        half = longint'(1) << (PHC_FRAC_BITS - 1);
        if (v >= 0) begin
            return (v + half) >>> PHC_FRAC_BITS;
        end else begin
            return -((-v + half) >>> PHC_FRAC_BITS);
        end
    endfunction

    function automatic longint err_mag(longint rounded, longint v);
        longint d;
        d = rounded * (longint'(1) << PHC_FRAC_BITS) - v;
        return (d < 0) ? -d : d;
    endfunction

    // Axial cell of a pixel under the current origin and scale
    function automatic hex_cell_t locate_cell(logic signed [15:0] px, logic signed [15:0] py);
        longint    ka, kb, kc, dx, dy, inv, fq, fr, fs, q, r, s, eq, er, es;
        hex_cell_t loc;
        ka = longint'((K_SQRT3_3_Q32 + (64'd1 << (31 - PHC_FRAC_BITS))) >> (32 - PHC_FRAC_BITS));
        kb = longint'((K_THIRD_Q32 + (64'd1 << (31 - PHC_FRAC_BITS))) >> (32 - PHC_FRAC_BITS));
        kc = longint'((K_TWO_THIRD_Q32 + (64'd1 << (31 - PHC_FRAC_BITS))) >> (32 - PHC_FRAC_BITS));
        dx = longint'(px) - longint'(org_x);
        dy = longint'(py) - longint'(org_y);
        inv = longint'(inv_scale);
        // scale into fractional axial coordinates, floor on the size multiply
        fq = ((ka * dx - kb * dy) * inv) >>> PHC_INV_FRAC;
        fr = ((kc * dy) * inv) >>> PHC_INV_FRAC;
        fs = -fq - fr;
        q = round_away(fq);
        r = round_away(fr);
        s = round_away(fs);
        eq = err_mag(q, fq);
        er = err_mag(r, fr);
        es = err_mag(s, fs);
        // rebuild the worst-rounded coordinate, strict comparisons on ties
        if (eq > er && eq > es) begin
            q = -r - s;
        end else if (er > es) begin
            r = -q - s;
        end
        loc.q = q[PHC_CELL_W-1:0];
        loc.r = r[PHC_CELL_W-1:0];
        return loc;
    endfunction

    // Source side: present pending pixels, with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cell_queue = {cell_queue, locate_cell(s_pixel_x, s_pixel_y)};
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    pixel_t px;
                    px = pixel_queue.pop_front();
                    s_valid <= 1'b1;
                    s_pixel_x <= px.x;
                    s_pixel_y <= px.y;
                    if (idle_on && $urandom_range(0, 5) == 0) begin
                        src_gap = $urandom_range(1, 9);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each transaction against the oldest expected cell
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cell_queue.size() == 0) begin
                    $error("unexpected result: cell_q %0d cell_r %0d", m_cell_q, m_cell_r);
                    fail_count++;
                end else begin
                    hex_cell_t want;
                    want = cell_queue.pop_front();
                    if (m_cell_q !== want.q) begin
                        $error("cell_q: expected %0d, got %0d", want.q, m_cell_q);
                        fail_count++;
                    end
                    if (m_cell_r !== want.r) begin
                        $error("cell_r: expected %0d, got %0d", want.r, m_cell_r);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    sink_gap = $urandom_range(1, 9);
                end
            end
        end
    end

    // Abort when no channel moves a transaction for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Call at a rising edge; leaves cfg_valid high at the accepting edge
    task automatic write_reg(logic [PHC_ADDR_W-1:0] addr, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (addr)
            REG_ORIGIN_X: org_x = data;
            REG_ORIGIN_Y: org_y = data;
            REG_INV_SIZE: inv_scale = data;
            default: ;
        endcase
    endtask

    task automatic load_config(logic [15:0] ox, logic [15:0] oy, logic [15:0] inv, bit poke_unused);
        @(posedge aclk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_INV_SIZE, inv);
        if (poke_unused) begin
            write_reg(REG_UNUSED, 16'($urandom));
        end
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_pixel(logic [15:0] x, logic [15:0] y);
        pixel_t px;
        px.x = x;
        px.y = y;
        pixel_queue = {pixel_queue, px};
    endtask

    // Wait until every pixel is out and every cell back, then let the pipe settle
    task automatic wait_idle();
        do @(negedge aclk); while (pixel_queue.size() != 0 || s_valid || cell_queue.size() != 0);
        repeat (PHC_STAGES + 2) @(posedge aclk);
    endtask

    // Pixel mostly within a few cells of the origin, sometimes anywhere
    function automatic logic [15:0] pick_coord(logic signed [15:0] org);
        int span;
        int offset;
        if ($urandom_range(0, 9) < 2) begin
            return 16'($urandom);
        end
        span = (inv_scale == 0) ? 2000 : (4 * 65536) / int'(inv_scale);
        if (span > 32767) begin
            span = 32767;
        end
        if (span < 2) begin
            span = 2;
        end
        offset = int'($urandom_range(0, 2 * span)) - span;
        return 16'(int'(org) + offset);
    endfunction

    function automatic logic [15:0] pick_origin();
        case ($urandom_range(0, 3))
            0, 1: return 16'(int'($urandom_range(0, 400)) - 200);
            2: return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 6))
            0: return 16'($urandom_range(1, 64));
            1: return 16'($urandom_range(65, 4096));
            2: return 16'($urandom);
            3: return 16'hFFFF;
            4: return 16'd1 << $urandom_range(0, 15);
            5: return INV_SIZE_RST;
            default: return $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 400));
        endcase
    endfunction

    initial begin
        logic [15:0] ox, oy, inv;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: centre, extremes, neighbors of the centre cell
        queue_pixel(16'd100, 16'd100);
        queue_pixel(16'h8000, 16'h8000);
        queue_pixel(16'h7FFF, 16'h7FFF);
        queue_pixel(16'h8000, 16'h7FFF);
        queue_pixel(16'h7FFF, 16'h8000);
        queue_pixel(16'd0, 16'd0);
        queue_pixel(16'hFFFF, 16'hFFFF);
        queue_pixel(16'd135, 16'd100);
        queue_pixel(16'd100, 16'd135);
        queue_pixel(16'd100, 16'd65);
        wait_idle();

        // Extreme origins with the largest scale
        load_config(16'h8000, 16'h8000, 16'hFFFF, 1'b0);
        queue_pixel(16'h7FFF, 16'h7FFF);
        queue_pixel(16'h8000, 16'h8000);
        queue_pixel(16'h7FFF, 16'h8000);
        wait_idle();
        load_config(16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
        queue_pixel(16'h8000, 16'h8000);
        queue_pixel(16'h8000, 16'h7FFF);
        wait_idle();

        // Zero scale collapses every pixel to the centre cell
        load_config(16'd0, 16'd0, 16'd0, 1'b1);
        queue_pixel(16'd1234, 16'hE9D2);
        queue_pixel(16'h7FFF, 16'h8000);
        wait_idle();

        // Pixels on the axes: equal and near-equal rounding errors
        load_config(16'd0, 16'd0, 16'h8000, 1'b1);
        queue_pixel(16'd0, 16'd0);
        queue_pixel(16'd0, 16'd1);
        queue_pixel(16'd0, 16'hFFFF);
        queue_pixel(16'd0, 16'd3);
        queue_pixel(16'd1, 16'd0);
        queue_pixel(16'hFFFF, 16'd0);
        wait_idle();

        // Random phases; the last one runs without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES - 1) begin
                idle_on = 1'b0;
            end
            ox = pick_origin();
            oy = pick_origin();
            inv = pick_scale();
            load_config(ox, oy, inv, $urandom_range(0, 2) == 0);
            repeat (PHASE_ITEMS) begin
                queue_pixel(pick_coord(org_x), pick_coord(org_y));
            end
            wait_idle();
        end

        repeat (2 * PHC_STAGES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[pixel_to_hex_cell.f]
+incdir+rtl
rtl/phc_pkg.sv
rtl/pixel_to_hex_cell.sv
rtl/phc_checker.sv
tb/testbench.sv
